### rtl/lmd_pkg.sv
// Shared types and constants of the damping update block.
package lmd_pkg;

  localparam int LAM_W = 40;
  localparam int DAT_W = 32;
  localparam int COST_W = 48;
  localparam int ACC_W = 64;
  localparam int EXP_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int IN_TDATA_W = 168;
  localparam int OUT_TDATA_W = 80;
  localparam int DIV_STEPS = 31;
  localparam int DIV_CNT_W = 5;

  localparam logic [LAM_W-1:0] LAM_MAX = {LAM_W{1'b1}};
  localparam logic [LAM_W-1:0] INIT_LAMBDA_RST = 40'd105;
  localparam logic [LAM_W-1:0] MIN_LAMBDA_RST = 40'd1;
  localparam logic [DAT_W-1:0] ONE_Q16 = 32'd65536;
  localparam logic [DAT_W-1:0] THIRD_Q16 = 32'd21845;

  localparam logic [CFG_IDX_W-1:0] REG_INIT_LAMBDA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LAMBDA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LAMBDA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAIN = 3'd3;

  localparam logic OP_RESTART = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_TERM, ST_ACC, ST_DSET, ST_DIV, ST_RHO,
    ST_CUBE1, ST_CUBE2, ST_FACT, ST_SCALE, ST_UPD
  } lmd_state_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic mul;
    logic term;
    logic acc;
    logic dset;
    logic div;
    logic rho;
    logic cube1;
    logic cube2;
    logic fact;
    logic scale;
    logic upd;
  } lmd_cmd_t;

  typedef struct packed {
    logic last_q;
    logic div_done;
    logic out_busy;
  } lmd_sts_t;

endpackage

### rtl/lmd_ctrl.sv
// Sequencer that steps the datapath through accumulate and update.
module lmd_ctrl
  import lmd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_op,
  output logic     in_tready,
  input  lmd_sts_t sts,
  output lmd_cmd_t cmd
);

  lmd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_op == OP_RESTART) begin
            cmd.restart = 1'b1;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = ST_TERM;
      end
      ST_TERM: begin
        cmd.term = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        state_nxt = sts.last_q ? ST_DSET : ST_IDLE;
      end
      ST_DSET: begin
        cmd.dset = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_done) begin
          state_nxt = ST_RHO;
        end
      end
      ST_RHO: begin
        cmd.rho = 1'b1;
        state_nxt = ST_CUBE1;
      end
      ST_CUBE1: begin
        cmd.cube1 = 1'b1;
        state_nxt = ST_CUBE2;
      end
      ST_CUBE2: begin
        cmd.cube2 = 1'b1;
        state_nxt = ST_FACT;
      end
      ST_FACT: begin
        cmd.fact = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.upd = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/lmd_dp.sv
// Datapath: element MAC, ratio divider, acceptance factor and damping update.
module lmd_dp
  import lmd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  lmd_cmd_t                cmd,
  output lmd_sts_t                sts,
  input  logic [IN_TDATA_W-1:0]   in_tdata,
  input  logic                    in_tlast,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_idx,
  input  logic [LAM_W-1:0]        cfg_data,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata
);

  // configuration
  logic [LAM_W-1:0] init_r, min_r, max_r;
  logic [DAT_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= INIT_LAMBDA_RST;
      min_r <= MIN_LAMBDA_RST;
      max_r <= LAM_MAX;
      thr_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_INIT_LAMBDA: init_r <= cfg_data;
        REG_MIN_LAMBDA:  min_r <= cfg_data;
        REG_MAX_LAMBDA:  max_r <= cfg_data;
        REG_MIN_GAIN:    thr_r <= cfg_data[DAT_W-1:0];
        default: ;
      endcase
    end
  end

  // latched item
  logic signed [DAT_W-1:0] dx_r, b_r;
  logic [COST_W-1:0] cl_r, cn_r;
  logic fin_r, last_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r <= in_tdata[31:0];
      b_r <= in_tdata[63:32];
      cl_r <= in_tdata[111:64];
      cn_r <= in_tdata[159:112];
      fin_r <= in_tdata[160];
      last_r <= in_tlast;
    end
  end

  // solver state
  logic [LAM_W-1:0] damp_r, damp_nxt;
  logic [EXP_W-1:0] exp_r, exp_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  // element term
  logic [DAT_W-1:0] mag_dx;
  logic [51:0] pp_hi_r, pp_lo_r;
  logic [52:0] pm;
  logic signed [54:0] s_full;
  logic signed [DAT_W-1:0] s_sat;
  logic signed [ACC_W-1:0] prod_r;
  logic signed [ACC_W:0] acc_sum;

  assign mag_dx = dx_r[31] ? (~dx_r + 32'd1) : dx_r;
  assign pm = {1'b0, pp_hi_r} + 53'(pp_lo_r >> 20);

  always_comb begin
    s_full = dx_r[31] ? -$signed({2'b00, pm}) : $signed({2'b00, pm});
    s_full = s_full + 55'(b_r);
    if (s_full > 55'sh7FFF_FFFF) begin
      s_sat = 32'sh7FFF_FFFF;
    end else if (s_full < -55'sh8000_0000) begin
      s_sat = 32'sh8000_0000;
    end else begin
      s_sat = s_full[31:0];
    end
  end

  assign acc_sum = {acc_r[63], acc_r} + {prod_r[63], prod_r};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pp_hi_r <= 52'(damp_r[39:20]) * 52'(mag_dx);
      pp_lo_r <= 52'(damp_r[19:0]) * 52'(mag_dx);
    end
    if (cmd.term) begin
      prod_r <= 64'(s_sat) * 64'(dx_r);
    end
  end

  // ratio setup and divider
  logic signed [48:0] d_w;
  logic signed [ACC_W-1:0] den_w;
  logic [48:0] nd_w;
  logic [ACC_W-1:0] nden_w;
  logic [64:0] rem_r, rem_sh;
  logic [ACC_W-1:0] dvs_r;
  logic [30:0] q_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic neg_r, spec_r;
  logic [DAT_W-1:0] spec_val_r;

  assign d_w = $signed({1'b0, cl_r}) - $signed({1'b0, cn_r});
  assign den_w = (acc_r == 64'sh7FFF_FFFF_FFFF_FFFF) ? acc_r : acc_r + 64'sd1;
  assign nd_w = d_w[48] ? 49'(-d_w) : 49'(d_w);
  assign nden_w = den_w[63] ? (~den_w + 64'd1) : den_w;
  assign rem_sh = {rem_r[63:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.dset) begin
      rem_r <= 65'(nd_w);
      dvs_r <= nden_w;
      q_r <= '0;
      cnt_r <= '0;
      neg_r <= d_w[48] ^ den_w[63];
      if (den_w == '0) begin
        spec_r <= 1'b1;
        spec_val_r <= d_w[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (64'(nd_w) >= nden_w) begin
        spec_r <= 1'b1;
        spec_val_r <= (d_w[48] ^ den_w[63]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        spec_r <= 1'b0;
        spec_val_r <= '0;
      end
    end else if (cmd.div) begin
      cnt_r <= cnt_r + 5'd1;
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_r <= rem_sh - {1'b0, dvs_r};
        q_r <= {q_r[29:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r <= {q_r[29:0], 1'b0};
      end
    end
  end

  // gain ratio and acceptance factor
  logic [DAT_W-1:0] rho_w, rho_r;
  logic signed [33:0] x_w;
  logic [33:0] ax_w;
  logic acc_ok_r, third_r, huge_r, xneg_r;
  logic [30:0] ax_r;
  logic [45:0] x2_r;
  logic [60:0] p1_r;
  logic [46:0] p2_r;
  logic [61:0] x3_w;
  logic [62:0] f_w;
  logic [LAM_W-1:0] f_r;
  logic fsat_r;

  assign rho_w = spec_r ? spec_val_r :
                 (neg_r ? (32'd0 - {1'b0, q_r}) : {1'b0, q_r});
  assign x_w = $signed({rho_w[31], rho_w[31], rho_w[30:0], 1'b0}) - 34'sd65536;
  assign ax_w = x_w[33] ? 34'(-x_w) : 34'(x_w);
  assign x3_w = 62'(p1_r) + 62'(p2_r >> 16);
  assign f_w = xneg_r ? 63'(ONE_Q16) + 63'(x3_w) : 63'(ONE_Q16) - 63'(x3_w);

  always_ff @(posedge clk) begin
    if (cmd.rho) begin
      rho_r <= rho_w;
      acc_ok_r <= ($signed(rho_w) > $signed(thr_r)) && fin_r;
      third_r <= (x_w >= 34'sd65536);
      xneg_r <= x_w[33];
      huge_r <= x_w[33] && (ax_w > 34'h4000_0000);
      ax_r <= ax_w[30:0];
    end
    if (cmd.cube1) begin
      x2_r <= 46'((62'(ax_r) * 62'(ax_r)) >> 16);
    end
    if (cmd.cube2) begin
      p1_r <= 61'(x2_r[45:16]) * 61'(ax_r);
      p2_r <= 47'(x2_r[15:0]) * 47'(ax_r);
    end
    if (cmd.fact) begin
      fsat_r <= huge_r || (!third_r && f_w >= 63'h100_0000_0000);
      if (third_r || f_w < 63'(THIRD_Q16)) begin
        f_r <= 40'(THIRD_Q16);
      end else begin
        f_r <= f_w[39:0];
      end
    end
  end

  // damping scale
  logic [63:0] hi_r;
  logic [55:0] lo_r;
  logic [40:0] sc_sum;
  logic [79:0] shl_w;
  logic [LAM_W-1:0] lam_w, lam_cl;

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      hi_r <= 64'(damp_r) * 64'(f_r[39:16]);
      lo_r <= 56'(damp_r) * 56'(f_r[15:0]);
    end
  end

  assign sc_sum = hi_r[40:0] + 41'(lo_r >> 16);
  assign shl_w = {40'd0, damp_r} << exp_r;

  always_comb begin
    if (acc_ok_r) begin
      if (damp_r == '0) begin
        lam_w = '0;
      end else if (fsat_r || hi_r > 64'(LAM_MAX) || sc_sum[40]) begin
        lam_w = LAM_MAX;
      end else begin
        lam_w = sc_sum[39:0];
      end
    end else begin
      if (damp_r == '0 || exp_r == '0) begin
        lam_w = damp_r;
      end else if (exp_r >= 6'd40 || shl_w[79:40] != '0) begin
        lam_w = LAM_MAX;
      end else begin
        lam_w = shl_w[39:0];
      end
    end
    lam_cl = (lam_w > max_r) ? max_r : lam_w;
    if (lam_cl < min_r) begin
      lam_cl = min_r;
    end
  end

  always_comb begin
    damp_nxt = damp_r;
    exp_nxt = exp_r;
    acc_nxt = acc_r;
    if (cmd.restart) begin
      damp_nxt = init_r;
      exp_nxt = 6'd1;
      acc_nxt = '0;
    end else if (cmd.acc) begin
      if (acc_sum[64] != acc_sum[63]) begin
        acc_nxt = acc_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      end else begin
        acc_nxt = acc_sum[63:0];
      end
    end else if (cmd.upd) begin
      damp_nxt = lam_cl;
      acc_nxt = '0;
      if (acc_ok_r) begin
        exp_nxt = 6'd1;
      end else if (exp_r != 6'd63) begin
        exp_nxt = exp_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_r <= INIT_LAMBDA_RST;
      exp_r <= 6'd1;
      acc_r <= '0;
    end else begin
      damp_r <= damp_nxt;
      exp_r <= exp_nxt;
      acc_r <= acc_nxt;
    end
  end

  // output register
  logic out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.upd) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_data_r <= {7'd0, rho_r, lam_cl, acc_ok_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  assign sts.last_q = last_r;
  assign sts.div_done = (cnt_r == 5'(DIV_STEPS - 1));
  assign sts.out_busy = out_valid_r && !out_tready;

endmodule

### rtl/lm_damping_update_unit.sv
// Levenberg-Marquardt damping update: top level.
//
// Input channel in_*: one item per vector element. in_tuser[0] is op
// (0 restart, 1 element); in_tlast marks the last element of a vector.
// Each element runs a multiply-accumulate of (lambda*dx + b)*dx into a
// saturating 64-bit accumulator through the MUL, TERM and ACC states;
// the next element is accepted once ACC has returned to idle. A restart
// is taken in the idle state and produces no result.
// On the last element the block goes on through DSET, then a restoring
// divider (DIV) forms the gain ratio, then the cube, factor and scaling
// steps run one multiply level per cycle, and UPD loads one result item
// into the out_* output register. The next item is accepted while it
// waits, and only a following result stalls in UPD until out_tready.
// Configuration is written by the user through cfg_we/cfg_idx/cfg_data
// only while idle; the block does not enforce it. Synchronous reset
// (rst_n low) loads the register defaults, damping 105, growth exponent
// 1 and a cleared accumulator.
module lm_damping_update_unit
  import lmd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // step_elem[31:0], grad_elem[63:32], cost_lin[111:64],
  // cost_new[159:112], cost_new_finite[160]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,   // op[0]
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // accepted[0], new_lambda[40:1], gain_ratio[72:41]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [LAM_W-1:0]       cfg_data
);

  lmd_cmd_t cmd;
  lmd_sts_t sts;

  lmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lmd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/lmd_chk.sv
// Port-level checker for the damping update block, bound to the top level.
module lmd_chk
  import lmd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tuser,
  input logic                   in_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !out_tvalid |=> !out_tvalid)
    else $error("restart produced a result");

  a_mid_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast && !out_tvalid |=> !out_tvalid)
    else $error("non-last element produced a result");

  a_elem_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("element accepted without a busy cycle");

endmodule

bind lm_damping_update_unit lmd_chk u_lmd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
